// ===== design/qbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// qbsp_pkg
// Shared widths, types and codes for the quadratic B-spline point generator.
// ----------------------------------------------------------------------------
package qbsp_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DENS_W     = 6;
  localparam logic [DENS_W-1:0] DENS_RESET = DENS_W'(5);
  localparam int OUT_W      = 24;

  // d^2, weights and the divisor 2*d^2
  localparam int SQ_W   = 2 * DENS_W;
  localparam int W_W    = SQ_W + 1;
  localparam int WX_W   = W_W + 2;
  localparam int DIV_W  = SQ_W + 1;
  // weighted sum, scaled numerator, quotient
  localparam int ACC_W  = COORD_BITS + DIV_W;
  localparam int N_W    = ACC_W + FRAC_BITS + 1;
  localparam int Q_W    = OUT_W;
  localparam int BCNT_W = $clog2(Q_W);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0x;
    logic signed [COORD_BITS-1:0] p0y;
    logic signed [COORD_BITS-1:0] p1x;
    logic signed [COORD_BITS-1:0] p1y;
    logic signed [COORD_BITS-1:0] p2x;
    logic signed [COORD_BITS-1:0] p2y;
    logic                         last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL0,
    BK_MUL1,
    BK_MUL2,
    BK_PREP,
    BK_ABS,
    BK_DIV,
    BK_FIX,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== design/qbsp_if.sv =====
// ----------------------------------------------------------------------------
// qbsp_if
// Valid/ready channels: control points in, curve samples out, density write.
// ----------------------------------------------------------------------------
interface qbsp_point_if import qbsp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface qbsp_sample_if import qbsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] curve_x;
  logic signed [OUT_W-1:0] curve_y;
  logic                    end_of_run;
  logic                    end_of_curve;

  modport source (output valid, curve_x, curve_y, end_of_run, end_of_curve, input ready);
  modport sink   (input valid, curve_x, curve_y, end_of_run, end_of_curve, output ready);
endinterface

interface qbsp_cfg_if import qbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DENS_W-1:0] density;

  modport source (output valid, density, input ready);
  modport sink   (input valid, density, output ready);
endinterface

// ===== design/qbsp_front.sv =====
// ----------------------------------------------------------------------------
// qbsp_front
// Takes control points, keeps the two-point window, queues segment jobs.
// ----------------------------------------------------------------------------
module qbsp_front import qbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qbsp_point_if.sink  points,
  input  q_stat_t     q_stat,
  output logic        push,
  output job_t        push_job
);

  logic [1:0]                   held, held_next;
  logic signed [COORD_BITS-1:0] w0x, w0x_next, w0y, w0y_next;
  logic signed [COORD_BITS-1:0] w1x, w1x_next, w1y, w1y_next;
  logic                         accept;

  assign points.ready = !q_stat.full;
  assign accept       = points.valid && points.ready;

  always_comb begin
    held_next = held;
    w0x_next  = w0x;
    w0y_next  = w0y;
    w1x_next  = w1x;
    w1y_next  = w1y;
    push      = accept && (held == 2'd2);
    push_job  = '{p0x: w0x, p0y: w0y, p1x: w1x, p1y: w1y,
                  p2x: points.point_x, p2y: points.point_y,
                  last: points.last_point};
    if (accept) begin
      if (held == 2'd0) begin
        w0x_next  = points.point_x;
        w0y_next  = points.point_y;
        held_next = 2'd1;
      end else if (held == 2'd1) begin
        w1x_next  = points.point_x;
        w1y_next  = points.point_y;
        held_next = 2'd2;
      end else begin
        w0x_next = w1x;
        w0y_next = w1y;
        w1x_next = points.point_x;
        w1y_next = points.point_y;
      end
      if (points.last_point) begin
        held_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else begin
      held <= held_next;
    end
  end

  // window entries are read only once counted as held
  always_ff @(posedge clk) begin
    w0x <= w0x_next;
    w0y <= w0y_next;
    w1x <= w1x_next;
    w1y <= w1y_next;
  end

endmodule

// ===== design/qbsp_queue.sv =====
// ----------------------------------------------------------------------------
// qbsp_queue
// Short job queue between the front and the sample engine.
// ----------------------------------------------------------------------------
module qbsp_queue import qbsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t stat
);

  job_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign pop_job    = mem[rd_ptr];
  assign stat.full  = (count == QCNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== design/qbsp_back.sv =====
// ----------------------------------------------------------------------------
// qbsp_back
// Sample engine: weights by differences, multiply-accumulate per lane,
// restoring divide by 2*d^2 with rounding, output register.
// ----------------------------------------------------------------------------
module qbsp_back import qbsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [DENS_W-1:0] density,
  input  q_stat_t           q_stat,
  input  job_t              q_job,
  output logic              pop,
  qbsp_sample_if.source     samples
);

  bk_state_t               state, state_next;
  job_t                    job, job_next;
  logic [DENS_W-1:0]       d, d_next, step, step_next;
  logic [SQ_W-1:0]         dd, dd_next;
  logic [DIV_W-1:0]        dv, dv_next;
  logic [W_W-1:0]          w0, w0_next, w1, w1_next, w2, w2_next;
  logic signed [ACC_W-1:0] acc_x, acc_x_next, acc_y, acc_y_next;
  logic signed [N_W-1:0]   n_x, n_x_next, n_y, n_y_next;
  logic                    neg_x, neg_x_next, neg_y, neg_y_next;
  logic [DIV_W-1:0]        rem_x, rem_x_next, rem_y, rem_y_next;
  logic [Q_W-1:0]          quo_x, quo_x_next, quo_y, quo_y_next;
  logic [BCNT_W-1:0]       bcnt, bcnt_next;
  logic signed [OUT_W-1:0] res_x, res_x_next, res_y, res_y_next;
  logic                    out_valid, out_valid_next;
  logic signed [OUT_W-1:0] out_x, out_x_next, out_y, out_y_next;
  logic                    out_eor, out_eor_next, out_eoc, out_eoc_next;

  logic [N_W-1:0]          mag_x, mag_y;
  logic [SQ_W-1:0]         sq;
  logic [WX_W-1:0]         w0_upd, w1_upd, w2_upd;
  logic                    last_sample;

  function automatic logic signed [ACC_W-1:0] mul_w(
    input logic signed [COORD_BITS-1:0] p,
    input logic [W_W-1:0]               w
  );
    logic signed [COORD_BITS+W_W:0] prod;
    prod  = p * signed'({1'b0, w});
    mul_w = prod[ACC_W-1:0];
  endfunction

  function automatic logic [DIV_W+Q_W-1:0] div_step(
    input logic [DIV_W-1:0] rem,
    input logic [Q_W-1:0]   quo,
    input logic [DIV_W-1:0] dvs
  );
    logic [DIV_W:0] part;
    logic [DIV_W:0] diff;
    part = {rem, quo[Q_W-1]};
    diff = part - {1'b0, dvs};
    if (part >= {1'b0, dvs}) begin
      div_step = {diff[DIV_W-1:0], quo[Q_W-2:0], 1'b1};
    end else begin
      div_step = {part[DIV_W-1:0], quo[Q_W-2:0], 1'b0};
    end
  endfunction

  // floor division of a negative value rounds the magnitude up
  function automatic logic signed [OUT_W-1:0] fix_q(
    input logic             neg,
    input logic [Q_W-1:0]   quo,
    input logic [DIV_W-1:0] rem
  );
    logic [Q_W:0]        mag;
    logic signed [Q_W:0] r;
    mag = {1'b0, quo} + (Q_W+1)'(neg && (rem != '0));
    r   = neg ? -signed'(mag) : signed'(mag);
    if (r[Q_W] != r[Q_W-1]) begin
      fix_q = r[Q_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      fix_q = r[OUT_W-1:0];
    end
  endfunction

  assign mag_x       = n_x[N_W-1] ? N_W'(-n_x) : N_W'(n_x);
  assign mag_y       = n_y[N_W-1] ? N_W'(-n_y) : N_W'(n_y);
  assign sq          = SQ_W'(d) * SQ_W'(d);
  assign last_sample = (step == d);

  assign w0_upd = WX_W'(w0) - WX_W'({d - step, 1'b0}) + WX_W'(1);
  assign w1_upd = WX_W'(w1) + WX_W'({d, 1'b0}) - WX_W'({step, 2'b00}) - WX_W'(2);
  assign w2_upd = WX_W'(w2) + WX_W'({step, 1'b0}) + WX_W'(1);

  assign samples.valid        = out_valid;
  assign samples.curve_x      = out_x;
  assign samples.curve_y      = out_y;
  assign samples.end_of_run   = out_eor;
  assign samples.end_of_curve = out_eoc;

  always_comb begin
    state_next     = state;
    job_next       = job;
    d_next         = d;
    step_next      = step;
    dd_next        = dd;
    dv_next        = dv;
    w0_next        = w0;
    w1_next        = w1;
    w2_next        = w2;
    acc_x_next     = acc_x;
    acc_y_next     = acc_y;
    n_x_next       = n_x;
    n_y_next       = n_y;
    neg_x_next     = neg_x;
    neg_y_next     = neg_y;
    rem_x_next     = rem_x;
    rem_y_next     = rem_y;
    quo_x_next     = quo_x;
    quo_y_next     = quo_y;
    bcnt_next      = bcnt;
    res_x_next     = res_x;
    res_y_next     = res_y;
    out_valid_next = out_valid && !samples.ready;
    out_x_next     = out_x;
    out_y_next     = out_y;
    out_eor_next   = out_eor;
    out_eoc_next   = out_eoc;
    pop            = 1'b0;

    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          job_next   = q_job;
          d_next     = (density == '0) ? DENS_W'(1) : density;
          state_next = BK_LOAD;
        end
      end
      BK_LOAD: begin
        dd_next    = sq;
        dv_next    = {sq, 1'b0};
        w0_next    = W_W'(sq);
        w1_next    = W_W'(sq);
        w2_next    = '0;
        step_next  = '0;
        state_next = BK_MUL0;
      end
      BK_MUL0: begin
        acc_x_next = mul_w(job.p0x, w0);
        acc_y_next = mul_w(job.p0y, w0);
        state_next = BK_MUL1;
      end
      BK_MUL1: begin
        acc_x_next = acc_x + mul_w(job.p1x, w1);
        acc_y_next = acc_y + mul_w(job.p1y, w1);
        state_next = BK_MUL2;
      end
      BK_MUL2: begin
        acc_x_next = acc_x + mul_w(job.p2x, w2);
        acc_y_next = acc_y + mul_w(job.p2y, w2);
        state_next = BK_PREP;
      end
      BK_PREP: begin
        // sum * 2^FRAC + d^2, then floor-divide by 2*d^2
        n_x_next   = (N_W'(acc_x) <<< FRAC_BITS) + signed'(N_W'(dd));
        n_y_next   = (N_W'(acc_y) <<< FRAC_BITS) + signed'(N_W'(dd));
        state_next = BK_ABS;
      end
      BK_ABS: begin
        neg_x_next = n_x[N_W-1];
        neg_y_next = n_y[N_W-1];
        rem_x_next = mag_x[Q_W +: DIV_W];
        rem_y_next = mag_y[Q_W +: DIV_W];
        quo_x_next = mag_x[Q_W-1:0];
        quo_y_next = mag_y[Q_W-1:0];
        bcnt_next  = '0;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        {rem_x_next, quo_x_next} = div_step(rem_x, quo_x, dv);
        {rem_y_next, quo_y_next} = div_step(rem_y, quo_y, dv);
        bcnt_next = bcnt + 1'b1;
        if (bcnt == BCNT_W'(Q_W - 1)) begin
          state_next = BK_FIX;
        end
      end
      BK_FIX: begin
        res_x_next = fix_q(neg_x, quo_x, rem_x);
        res_y_next = fix_q(neg_y, quo_y, rem_y);
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid || samples.ready) begin
          out_valid_next = 1'b1;
          out_x_next     = res_x;
          out_y_next     = res_y;
          out_eor_next   = last_sample;
          out_eoc_next   = last_sample && job.last;
          if (last_sample) begin
            state_next = BK_IDLE;
          end else begin
            w0_next    = w0_upd[W_W-1:0];
            w1_next    = w1_upd[W_W-1:0];
            w2_next    = w2_upd[W_W-1:0];
            step_next  = step + 1'b1;
            state_next = BK_MUL0;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    job   <= job_next;
    d     <= d_next;
    step  <= step_next;
    dd    <= dd_next;
    dv    <= dv_next;
    w0    <= w0_next;
    w1    <= w1_next;
    w2    <= w2_next;
    acc_x <= acc_x_next;
    acc_y <= acc_y_next;
    n_x   <= n_x_next;
    n_y   <= n_y_next;
    neg_x <= neg_x_next;
    neg_y <= neg_y_next;
    rem_x <= rem_x_next;
    rem_y <= rem_y_next;
    quo_x <= quo_x_next;
    quo_y <= quo_y_next;
    bcnt  <= bcnt_next;
    res_x <= res_x_next;
    res_y <= res_y_next;
    out_x <= out_x_next;
    out_y <= out_y_next;
    out_eor <= out_eor_next;
    out_eoc <= out_eoc_next;
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job taken from an empty queue");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIV |-> (rem_x < dv) && (rem_y < dv))
    else $error("partial remainder not below divisor");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) && (state != BK_LOAD) |-> step <= d)
    else $error("sample index past density");

  a_eoc_on_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eoc |-> out_eor)
    else $error("curve end flagged on a sample that does not end its run");

endmodule

// ===== design/quadratic_bspline_point_generator_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_bspline_point_generator_core
// Uniform quadratic B-spline sampler over a stream of 2-D control points.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake    Payload
// points   in   valid/ready  point_x, point_y, last_point
// samples  out  valid/ready  curve_x, curve_y, end_of_run, end_of_curve
// cfg      in   valid/ready  density (ready always high)
//
// A point that only fills the window is taken without pushing a job.
// A point that closes a segment gives the engine a job of d+1 samples;
// each sample runs the MAC states MUL0, MUL1 and MUL2, the setup states
// PREP and ABS, a 24-bit restoring divider by 2*d^2, then FIX and EMIT,
// x and y in parallel lanes.
// A two-entry job queue lets points be taken while the engine works.
// Synchronous reset empties queue and window, idles the engine, density = 5.
// A stalled sample holds in the output register; the engine waits behind it.
// ----------------------------------------------------------------------------
module quadratic_bspline_point_generator_core import qbsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  qbsp_point_if.sink    points,
  qbsp_sample_if.source samples,
  qbsp_cfg_if.sink      cfg
);

  logic [DENS_W-1:0] density;
  q_stat_t           q_stat;
  logic              push, pop;
  job_t              push_job, pop_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      density <= DENS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      density <= cfg.density;
    end
  end

  qbsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .points   (points),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  qbsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  qbsp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .density (density),
    .q_stat  (q_stat),
    .q_job   (pop_job),
    .pop     (pop),
    .samples (samples)
  );

endmodule
